### rtl/mtt_pkg.sv
// shared constants, codes and types of the multi timer table
package mtt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int RESULT_CAP = 16;
    localparam int CNT_W      = $clog2(RESULT_CAP + 1);

    localparam int ID_W   = 31;
    localparam int DUR_W  = 32;
    localparam int TIME_W = 64;
    localparam int CMD_W  = 2;
    localparam int KIND_W = 3;

    localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};
    localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);

    localparam logic [CMD_W-1:0] CMD_SCHED  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_SCHEDULED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [DUR_W-1:0] duration_ms;
        logic             periodic;
        logic [ID_W-1:0]  target_id;
    } t_in;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   event_id;
        logic              last;
    } t_out;

    // token that walks the row of slot cells, one cell per cycle
    typedef struct packed {
        logic             vld;
        logic             hit;
        logic             fire;
        logic [ID_W-1:0]  fire_id;
        logic [CNT_W-1:0] fire_cnt;
    } t_tok;

    // item data seen by every cell while the token walks
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] new_due;
        logic [DUR_W-1:0]  period;
        logic              periodic;
        logic [ID_W-1:0]   new_id;
        logic [ID_W-1:0]   target_id;
    } t_bcast;

endpackage

### rtl/mtt_cell.sv
// one timer slot: holds its timer and acts on the token as it passes
module mtt_cell
    import mtt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_tok   i_tok,
    input  t_bcast i_bc,
    output t_tok   o_tok
);

    logic              r_valid;
    logic [ID_W-1:0]   r_id;
    logic [DUR_W-1:0]  r_period;
    logic [TIME_W-1:0] r_due;
    logic              r_repeat;
    t_tok              r_tok;

    logic n_valid;
    t_tok n_tok;
    logic wr_slot;
    logic adv_due;
    logic due_hit;

    assign due_hit = (r_due <= i_bc.now_ms);

    always_comb begin
        n_valid      = r_valid;
        n_tok        = i_tok;
        n_tok.fire   = 1'b0;
        n_tok.fire_id = r_id;
        wr_slot      = 1'b0;
        adv_due      = 1'b0;
        if (i_tok.vld) begin
            unique case (i_bc.cmd)
                CMD_SCHED: begin
                    // lowest free slot takes the new timer
                    if (!r_valid && !i_tok.hit) begin
                        wr_slot   = 1'b1;
                        n_valid   = 1'b1;
                        n_tok.hit = 1'b1;
                    end
                end
                CMD_CANCEL: begin
                    if (r_valid && !i_tok.hit && r_id == i_bc.target_id) begin
                        n_valid   = 1'b0;
                        n_tok.hit = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (r_valid && due_hit && i_tok.fire_cnt < CNT_W'(RESULT_CAP)) begin
                        n_tok.fire     = 1'b1;
                        n_tok.fire_cnt = i_tok.fire_cnt + CNT_W'(1);
                        if (r_repeat) begin
                            adv_due = 1'b1;
                        end else begin
                            n_valid = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= i_tok.vld ? n_tok : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_slot) begin
            r_id     <= i_bc.new_id;
            r_period <= i_bc.period;
            r_due    <= i_bc.new_due;
            r_repeat <= i_bc.periodic;
        end else if (adv_due) begin
            r_due <= r_due + TIME_W'(r_period);
        end
    end

    assign o_tok = r_tok;

endmodule

### rtl/multi_timer_table.sv
// multi timer table: top level with sequencer and the row of slot cells
//
// Usage: drive i_item and raise start; the item is taken at an edge where
// start is high and busy is low. cmd schedule places a timer in the lowest
// free slot and returns its id, cancel frees the lowest slot with the given
// id, tick advances time by one millisecond and fires every due timer in slot
// order (at most 16 per tick). Each beat is valid on o_result for exactly
// one cycle, flagged by o_strobe; the receiver cannot stall, so every beat
// must be taken when shown. The final beat of an item carries last.
// A token walks the row of NUM_TIMERS cells, one cell per cycle; busy stays
// high while the token walks and through the flush state, and no new item is
// taken until busy falls. Fired beats appear while the token walks; the last
// beat shows as busy falls, in the same cycle. Quiet ticks and unknown
// commands give no beat. Reset clears time to zero, the next id to one and all
// slots to free; no clearing pass is needed.
module multi_timer_table
    import mtt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_strobe,
    output t_out o_result
);

    t_state            r_state, n_state;
    logic [TIME_W-1:0] r_now, n_now;
    logic [ID_W-1:0]   r_next_id, n_next_id;
    t_tok              r_inj, n_inj;
    t_out              r_out, n_out;
    logic              r_strobe, n_strobe;
    t_out              r_pend, n_pend;
    logic              r_pend_vld, n_pend_vld;

    logic [CMD_W-1:0]  r_cmd;
    logic [DUR_W-1:0]  r_dur;
    logic              r_rep;
    logic [ID_W-1:0]   r_target;
    logic [TIME_W-1:0] r_new_due;

    t_bcast bc;
    t_tok   tok [NUM_TIMERS];
    logic   any_fire;
    logic [ID_W-1:0] fire_id;
    logic   scan_done;
    logic   scan_hit;
    logic   accept;
    logic [NUM_TIMERS:0] tok_vld;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    assign bc.cmd       = r_cmd;
    assign bc.now_ms    = r_now;
    assign bc.new_due   = r_new_due;
    assign bc.period    = r_dur;
    assign bc.periodic  = r_rep;
    assign bc.new_id    = r_next_id;
    assign bc.target_id = r_target;

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        if (g == 0) begin : g_head
            mtt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (r_inj),
                .i_bc    (bc),
                .o_tok   (tok[g])
            );
        end else begin : g_body
            mtt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (tok[g-1]),
                .i_bc    (bc),
                .o_tok   (tok[g])
            );
        end
    end

    // only one token is live, so an and-or over the cells picks the firing one
    always_comb begin
        any_fire = 1'b0;
        fire_id  = '0;
        tok_vld  = '0;
        tok_vld[NUM_TIMERS] = r_inj.vld;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            tok_vld[i] = tok[i].vld;
            if (tok[i].vld && tok[i].fire) begin
                any_fire = 1'b1;
                fire_id  = fire_id | tok[i].fire_id;
            end
        end
    end

    assign scan_done = tok[NUM_TIMERS-1].vld;
    assign scan_hit  = tok[NUM_TIMERS-1].hit;

    always_comb begin
        n_state    = r_state;
        n_now      = r_now;
        n_next_id  = r_next_id;
        n_inj      = '0;
        n_out      = r_out;
        n_strobe   = 1'b0;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_inj.vld = 1'b1;
                    n_state   = ST_SCAN;
                    if (i_item.cmd == CMD_TICK) begin
                        n_now = r_now + TIME_W'(1);
                    end
                end
            end
            ST_SCAN: begin
                // hold each fire back one beat so the final one can carry last
                if (any_fire) begin
                    n_strobe      = r_pend_vld;
                    n_out         = r_pend;
                    n_out.last    = 1'b0;
                    n_pend.kind   = KIND_FIRED;
                    n_pend.event_id = fire_id;
                    n_pend.last   = 1'b0;
                    n_pend_vld    = 1'b1;
                end
                if (scan_done) begin
                    n_state = ST_FLUSH;
                    if (r_cmd == CMD_SCHED) begin
                        n_pend_vld  = 1'b1;
                        n_pend.last = 1'b0;
                        if (scan_hit) begin
                            n_pend.kind     = KIND_SCHEDULED;
                            n_pend.event_id = r_next_id;
                            n_next_id = (r_next_id >= ID_MAX) ? ID_FIRST
                                                              : r_next_id + ID_W'(1);
                        end else begin
                            n_pend.kind     = KIND_FULL;
                            n_pend.event_id = '0;
                        end
                    end else if (r_cmd == CMD_CANCEL) begin
                        n_pend_vld      = 1'b1;
                        n_pend.last     = 1'b0;
                        n_pend.kind     = scan_hit ? KIND_CANCELLED : KIND_NOT_FOUND;
                        n_pend.event_id = r_target;
                    end
                end
            end
            ST_FLUSH: begin
                n_strobe   = r_pend_vld;
                n_out      = r_pend;
                n_out.last = 1'b1;
                n_pend_vld = 1'b0;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_now      <= '0;
            r_next_id  <= ID_FIRST;
            r_inj      <= '0;
            r_strobe   <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_now      <= n_now;
            r_next_id  <= n_next_id;
            r_inj      <= n_inj;
            r_strobe   <= n_strobe;
            r_pend_vld <= n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
        if (accept) begin
            r_cmd     <= i_item.cmd;
            r_dur     <= i_item.duration_ms;
            r_rep     <= i_item.periodic;
            r_target  <= i_item.target_id;
            r_new_due <= r_now + TIME_W'(i_item.duration_ms);
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_vld))
        else $error("more than one token in the cell row");

    a_inject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_inj.vld && r_state == ST_SCAN)
        else $error("accepted item did not start a scan");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> r_state == ST_IDLE)
        else $error("final beat shown while still busy");

    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id != '0)
        else $error("next id reached zero");

    a_done_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan_done && r_state == ST_SCAN) |=> r_state == ST_FLUSH)
        else $error("end of scan did not lead to flush");

endmodule

### test/multi_timer_table_test.sv
// self-checking testbench of the multi timer table: directed plan, then random commands
`timescale 1ns / 100ps

module multi_timer_table_test;
    import mtt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam int N_RANDOM     = 104;
    localparam int IDLE_LIMIT   = 400;
    localparam int DRAIN_CYCLES = NUM_TIMERS + 8;
    localparam int MAX_REPORTS  = 10;
    localparam int PLAN_ROWS    = 13;

    typedef struct {
        t_in               item;
        int                n_reps;
        bit                typed;
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    logic o_strobe;
    t_out o_result;

    multi_timer_table i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // own copy of the timer table
    logic [TIME_W-1:0] clock_ms;
    logic [ID_W-1:0]   id_next;
    logic              live       [NUM_TIMERS];
    logic [ID_W-1:0]   tmr_id     [NUM_TIMERS];
    logic [DUR_W-1:0]  tmr_period [NUM_TIMERS];
    logic [TIME_W-1:0] tmr_due    [NUM_TIMERS];
    logic              tmr_repeat [NUM_TIMERS];

    t_out step_beats[$];
    t_out expected_events[$];

    int mismatches  = 0;
    int items_sent  = 0;
    int beats_seen  = 0;
    int fires_seen  = 0;
    int full_seen   = 0;
    int idle_cycles = 0;
    int calm_left   = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // append one beat of the command being modeled
    function automatic void add_beat(input t_out b);
        step_beats.insert(step_beats.size(), b);
    endfunction

    // append one beat to the list the result side checks against
    function automatic void expect_beat(input t_out b);
        expected_events.insert(expected_events.size(), b);
    endfunction

    // advance the table by one command and leave its beats in step_beats
    function automatic void apply_timer_cmd(input t_in it);
        int   free_slot;
        bit   found;
        step_beats.delete();
        case (it.cmd)
            CMD_SCHED: begin
                free_slot = -1;
                for (int i = 0; i < NUM_TIMERS; i++)
                    if (!live[i] && free_slot < 0) free_slot = i;
                if (free_slot < 0) begin
                    add_beat('{kind: KIND_FULL, event_id: '0, last: 1'b0});
                end else begin
                    live[free_slot]       = 1'b1;
                    tmr_id[free_slot]     = id_next;
                    tmr_period[free_slot] = it.duration_ms;
                    tmr_due[free_slot]    = clock_ms + TIME_W'(it.duration_ms);
                    tmr_repeat[free_slot] = it.periodic;
                    add_beat('{kind: KIND_SCHEDULED, event_id: id_next, last: 1'b0});
                    id_next = (id_next == ID_MAX) ? ID_FIRST : id_next + 1'b1;
                end
            end
            CMD_CANCEL: begin
                found = 1'b0;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (!found && live[i] && tmr_id[i] == it.target_id) begin
                        live[i] = 1'b0;
                        found   = 1'b1;
                    end
                end
                add_beat('{kind: found ? KIND_CANCELLED : KIND_NOT_FOUND,
                           event_id: it.target_id, last: 1'b0});
            end
            CMD_TICK: begin
                clock_ms = clock_ms + 1'b1;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (live[i] && tmr_due[i] <= clock_ms
                        && step_beats.size() < RESULT_CAP) begin
                        add_beat('{kind: KIND_FIRED, event_id: tmr_id[i], last: 1'b0});
                        if (tmr_repeat[i])
                            tmr_due[i] = tmr_due[i] + TIME_W'(tmr_period[i]);
                        else
                            live[i] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_beat(input t_out got);
        t_out want;
        beats_seen++;
        if (got.kind == KIND_FIRED) fires_seen++;
        if (got.kind == KIND_FULL) full_seen++;
        if (expected_events.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("beat %0d unexpected: kind %0d id %0d last %0b",
                         beats_seen, got.kind, got.event_id, got.last);
        end else begin
            want = expected_events.pop_front();
            if (got.kind !== want.kind || got.event_id !== want.event_id
                || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("beat %0d: expected kind %0d id %0d last %0b, got %0d %0d %0b",
                             beats_seen, want.kind, want.event_id, want.last,
                             got.kind, got.event_id, got.last);
            end
        end
    endfunction

    // result side and watchdog, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d cycles without a beat", idle_cycles);
                $display("multi_timer_table: mismatch");
                $finish;
            end else if (o_strobe) begin
                check_beat(o_result);
            end
        end
    end

    // one command beat: random hold-off, then hold start until taken
    task automatic send_item(input t_in it, input bit typed, input t_out typed_beat);
        int gap;
        @(negedge i_clk);
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(8, 20);
            gap       = 0;
        end else begin
            gap = $urandom_range(0, 7);
        end
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  = 1'b1;
        i_item = it;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        items_sent++;
        apply_timer_cmd(it);
        if (typed)
            expect_beat(typed_beat);
        else
            foreach (step_beats[i]) expect_beat(step_beats[i]);
    endtask

    function automatic t_row plan_row(input logic [CMD_W-1:0] cmd, input logic [DUR_W-1:0] dur,
                                      input logic per, input logic [ID_W-1:0] tid,
                                      input int reps, input bit typed,
                                      input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id);
        t_row r;
        r.item   = '{cmd: cmd, duration_ms: dur, periodic: per, target_id: tid};
        r.n_reps = reps;
        r.typed  = typed;
        r.kind   = kind;
        r.id     = id;
        return r;
    endfunction

    initial begin
        t_row plan[PLAN_ROWS];
        t_in  it;
        t_out tb;
        int   pick;
        int   n_random;
        int   live_idx[$];

        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_item   = '0;
        clock_ms = '0;
        id_next  = ID_FIRST;
        foreach (live[i]) live[i] = 1'b0;

        plan[0]  = plan_row(CMD_CANCEL, '0, 1'b0, 31'd5, 1, 1, KIND_NOT_FOUND, 31'd5);
        plan[1]  = plan_row(CMD_CANCEL, '0, 1'b0, ID_MAX, 1, 1, KIND_NOT_FOUND, ID_MAX);
        plan[2]  = plan_row(CMD_TICK, '0, 1'b0, '0, 1, 0, KIND_FIRED, '0);       // quiet tick
        plan[3]  = plan_row(CMD_UNKNOWN, '1, 1'b1, ID_MAX, 1, 0, KIND_FIRED, '0);
        plan[4]  = plan_row(CMD_SCHED, '0, 1'b0, '0, 1, 1, KIND_SCHEDULED, ID_FIRST);
        plan[5]  = plan_row(CMD_SCHED, 32'd1, 1'b1, '0, 1, 0, KIND_SCHEDULED, '0);
        // fill the rest of the table with period-zero timers
        plan[6]  = plan_row(CMD_SCHED, '0, 1'b1, '0, NUM_TIMERS - 2, 0, KIND_SCHEDULED, '0);
        plan[7]  = plan_row(CMD_SCHED, 32'd5, 1'b0, '0, 1, 1, KIND_FULL, '0);
        plan[8]  = plan_row(CMD_TICK, '0, 1'b0, '0, 1, 0, KIND_FIRED, '0);       // all slots fire
        plan[9]  = plan_row(CMD_TICK, '0, 1'b0, '0, 1, 0, KIND_FIRED, '0);
        plan[10] = plan_row(CMD_SCHED, '1, 1'b1, '0, 1, 0, KIND_SCHEDULED, '0);
        plan[11] = plan_row(CMD_CANCEL, '0, 1'b0, 31'd3, 1, 1, KIND_CANCELLED, 31'd3);
        plan[12] = plan_row(CMD_CANCEL, '0, 1'b0, 31'd3, 1, 1, KIND_NOT_FOUND, 31'd3);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[r]) begin
            tb = '{kind: plan[r].kind, event_id: plan[r].id, last: 1'b1};
            repeat (plan[r].n_reps) send_item(plan[r].item, plan[r].typed, tb);
        end

        n_random = 0;
        while (n_random < N_RANDOM) begin
            it.duration_ms = $urandom;
            it.periodic    = 1'($urandom_range(0, 1));
            it.target_id   = ID_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                it.cmd = CMD_SCHED;
                case ($urandom_range(0, 9))
                    0: it.duration_ms = $urandom;
                    1: it.duration_ms = '1;
                    2: it.duration_ms = DUR_W'(1) << $urandom_range(0, DUR_W - 1);
                    default: it.duration_ms = $urandom_range(0, 6);
                endcase
            end else if (pick < 50) begin
                // cancel a timer that is live right now, if there is one
                it.cmd = CMD_CANCEL;
                live_idx.delete();
                foreach (live[i]) if (live[i]) live_idx.insert(live_idx.size(), i);
                if (live_idx.size() > 0)
                    it.target_id = tmr_id[live_idx[$urandom_range(0, live_idx.size() - 1)]];
            end else if (pick < 58) begin
                it.cmd = CMD_CANCEL;
                if ($urandom_range(0, 1) == 0)
                    it.target_id = ID_W'($urandom_range(0, int'(id_next)));
            end else if (pick < 95) begin
                it.cmd = CMD_TICK;
            end else begin
                it.cmd = CMD_UNKNOWN;
            end
            n_random++;
            send_item(it, 1'b0, '0);
        end

        @(negedge i_clk);
        start = 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d command beats sent, %0d result beats checked", items_sent, beats_seen);
        $display("%0d timer fires, %0d table-full replies, %0d mismatches",
                 fires_seen, full_seen, mismatches);
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("multi_timer_table: match");
        end else begin
            $display("multi_timer_table: mismatch");
        end
        $finish;
    end

endmodule

### files.f
rtl/mtt_pkg.sv
rtl/mtt_cell.sv
rtl/multi_timer_table.sv
test/multi_timer_table_test.sv
